// ----- rtl/tap_tempo_controller_macros.svh -----
// ----------------------------------------------------------------------------
// tap tempo controller assertion macros
// checks that can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_CONTROLLER_MACROS_SVH
`define TAP_TEMPO_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, quiet during reset
`define TT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tap tempo check failed");

// next-cycle implication, quiet during reset
`define TT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tap tempo check failed");

`else

`define TT_ASSERT_IMP(lbl, ante, cons)
`define TT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/tt_pkg.sv -----
// ----------------------------------------------------------------------------
// tt_pkg
// widths, constants and helper functions of the tap tempo controller
// ----------------------------------------------------------------------------
`default_nettype none

package tt_pkg;

	localparam int DATA_W   = 16;
	localparam int SAMPLE_W = 10;
	localparam int TCNT_W   = 8;
	localparam int CODE_W   = 3;
	localparam int DIVD_W   = 20;
	localparam int DIVS_W   = 4;
	localparam int REM_W    = 4;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam int TICKS_PER_MS_DEF = 20;

	// thresholds
	localparam logic [DATA_W-1:0]   SW_JUMP      = 16'd300;
	localparam logic [DATA_W-1:0]   POT_JUMP_TAP = 16'd72;
	localparam logic [11:0]         SINGLE_SLACK = 12'd800;
	localparam logic [DATA_W-1:0]   MIN_TAP_MS   = 16'd100;
	localparam logic [SAMPLE_W-1:0] SW_LOW       = 10'd100;
	localparam logic [SAMPLE_W-1:0] SW_HIGH      = 10'd900;
	localparam logic [DATA_W-1:0]   BLINK_ON_MS  = 16'd8;
	localparam logic [17:0]         BLINK_LEAD   = 18'd4;
	localparam logic [DATA_W-1:0]   LAST_INIT    = 16'd60000;
	localparam logic [DATA_W-1:0]   DRIVE_INIT   = 16'd500;
	localparam logic [CODE_W-1:0]   BTN_CODE_OFS = 3'd3;
	localparam logic [TCNT_W-1:0]   TCNT_MAX     = 8'd255;

	// register reset values
	localparam logic [9:0]        DELAY_MAX_RST   = 10'd1000;
	localparam logic [9:0]        POT_SCALE_RST   = 10'd1;
	localparam logic [DATA_W-1:0] START_TEMPO_RST = 16'd500;
	localparam logic              START_TAP_RST   = 1'b0;

	typedef enum logic [1:0] {
		REG_DELAY_MAX   = 2'd0,
		REG_POT_SCALE   = 2'd1,
		REG_START_TEMPO = 2'd2,
		REG_START_TAP   = 2'd3
	} reg_idx_t;

	// subdivision numerator: 3 for three quarters, else 1
	function automatic logic [1:0] mult_num(input logic [CODE_W-1:0] code);
		logic [1:0] n;
		case (code)
			3'd1:    n = 2'd3;
			default: n = 2'd1;
		endcase
		return n;
	endfunction

	// subdivision denominator
	function automatic logic [2:0] mult_den(input logic [CODE_W-1:0] code);
		logic [2:0] d;
		case (code)
			3'd1:    d = 3'd4;
			3'd2:    d = 3'd2;
			3'd3:    d = 3'd3;
			3'd4:    d = 3'd4;
			3'd5:    d = 3'd6;
			default: d = 3'd1;
		endcase
		return d;
	endfunction

	function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [DATA_W-1:0] sat_from20(input logic [DIVD_W-1:0] v);
		return (v[DIVD_W-1:DATA_W] != '0) ? '1 : v[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tap_tempo_controller.sv -----
// a poll passes through phases a, b and c to the result beat, with a pass
// through the shared 20-step divider when a switch change or a tap needs one
// throughput: one poll at a time, next beat taken once the result is delivered
// the bit-serial restoring divider computes one quotient bit a cycle
// reset: control state and registers load reset values at once, no clearing pass; poll latches have no reset
`default_nettype none

`include "tap_tempo_controller_macros.svh"

// ----------------------------------------------------------------------------
// tap_tempo_controller
// tap tempo with subdivision, idle timeout, pot fallback and beat led
// ----------------------------------------------------------------------------
module tap_tempo_controller #(
	parameter int TICKS_PER_MS = tt_pkg::TICKS_PER_MS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tt_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [tt_pkg::PDATA_W-1:0]    pwdata,
	output logic      [tt_pkg::PDATA_W-1:0]    prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          fine_tick,
	input  wire logic                          button,
	input  wire logic [tt_pkg::SAMPLE_W-1:0]   pot_sample,
	input  wire logic [tt_pkg::SAMPLE_W-1:0]   switch_sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [tt_pkg::DATA_W-1:0]     delay_value,
	output logic                               led_on,
	output logic                               tap_control
);
	import tt_pkg::*;

	localparam int FCW   = $clog2(TICKS_PER_MS);
	localparam int FCW1  = FCW + 1;
	localparam int HALF  = TICKS_PER_MS / 2;
	localparam int CNT_W = $clog2(DIVD_W);

	typedef enum logic [2:0] {
		S_IDLE, S_A, S_B, S_DIV, S_WR, S_C
	} state_t;

	state_t state_q;

	// configuration registers
	logic [9:0]        delay_max_q;
	logic [9:0]        pot_scale_q;
	logic [DATA_W-1:0] start_tempo_q;
	logic              start_tap_q;

	// latched poll
	logic                tick_q, btn_q;
	logic [SAMPLE_W-1:0] pot_q, sw_q;

	// controller state
	logic [FCW-1:0]    fine_count_q;
	logic [DATA_W-1:0] elapsed_q, blink_q, tempo_q, divided_q;
	logic [DATA_W-1:0] last_switch_q, last_pot_q, drive_q;
	logic [TCNT_W-1:0] tap_count_q;
	logic [CODE_W-1:0] code_q;
	logic              held_q, tapping_q, tap_mode_q, led_q, first_seen_q;

	// divider
	logic [DIVD_W-1:0] quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [DIVS_W-1:0] divs_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic              div_from_b_q;

	// result register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_delay_q;
	logic              out_led_q, out_tap_q;

	// ---------------------------------------------------------------- cfg port
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			REG_DELAY_MAX:   prdata = {22'd0, delay_max_q};
			REG_POT_SCALE:   prdata = {22'd0, pot_scale_q};
			REG_START_TEMPO: prdata = {16'd0, start_tempo_q};
			REG_START_TAP:   prdata = {31'd0, start_tap_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_max_q   <= DELAY_MAX_RST;
			pot_scale_q   <= POT_SCALE_RST;
			start_tempo_q <= START_TEMPO_RST;
			start_tap_q   <= START_TAP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DELAY_MAX:   delay_max_q   <= pwdata[9:0];
				REG_POT_SCALE:   pot_scale_q   <= pwdata[9:0];
				REG_START_TEMPO: start_tempo_q <= pwdata[DATA_W-1:0];
				REG_START_TAP:   start_tap_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	logic in_take, out_take;

	assign in_stall    = (state_q != S_IDLE) || out_valid_q;
	assign in_take     = in_valid && !in_stall;
	assign out_take    = out_valid_q && !out_stall;
	assign out_valid   = out_valid_q;
	assign delay_value = out_delay_q;
	assign led_on      = out_led_q;
	assign tap_control = out_tap_q;

	// poll payload capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			tick_q <= fine_tick;
			btn_q  <= button;
			pot_q  <= pot_sample;
			sw_q   <= switch_sample;
		end
	end

	// ---------------------------------------------------------------- phase a
	// first poll load, tick counting and division switch
	logic              tm_a, roll_a, sw_chg_a, clr_a, div_a;
	logic [DATA_W-1:0] tempo_a, lpot_a, el_t, bl_t, el_a, bl_a, lsw_a, sw_ext, pot_ext;
	logic [FCW1-1:0]   fc_inc;
	logic [FCW-1:0]    fc_a;
	logic [CODE_W-1:0] pos_a, code_a;
	logic [TCNT_W-1:0] tcnt_a;
	logic              tapping_a, held_a;
	logic [17:0]       tn_a;
	logic [DIVD_W-1:0] dvd_a;
	logic [DIVS_W-1:0] dvs_a;
	logic [1:0]        n_a;
	logic [2:0]        d_a;

	assign sw_ext  = {6'd0, sw_q};
	assign pot_ext = {6'd0, pot_q};

	always_comb begin
		tm_a    = first_seen_q ? tap_mode_q : start_tap_q;
		tempo_a = first_seen_q ? tempo_q : start_tempo_q;
		lpot_a  = first_seen_q ? last_pot_q : (start_tap_q ? pot_ext : LAST_INIT);

		fc_inc = {1'b0, fine_count_q} + 1'b1;
		roll_a = tick_q && (fc_inc >= FCW1'(TICKS_PER_MS));
		fc_a   = !tick_q ? fine_count_q : (roll_a ? '0 : fc_inc[FCW-1:0]);
		el_t   = roll_a ? sat_inc(elapsed_q) : elapsed_q;
		bl_t   = roll_a ? sat_inc(blink_q) : blink_q;

		sw_chg_a = abs_diff(last_switch_q, sw_ext) > SW_JUMP;
		pos_a    = (sw_q <= SW_LOW) ? 3'd0 : ((sw_q < SW_HIGH) ? 3'd1 : 3'd2);
		code_a   = sw_chg_a ? (btn_q ? pos_a + BTN_CODE_OFS : pos_a) : code_q;
		clr_a    = sw_chg_a && btn_q;

		tcnt_a    = clr_a ? '0 : tap_count_q;
		tapping_a = clr_a ? 1'b0 : tapping_q;
		el_a      = clr_a ? '0 : el_t;
		held_a    = clr_a ? 1'b1 : held_q;
		bl_a      = sw_chg_a ? '0 : bl_t;
		lsw_a     = sw_chg_a ? sw_ext : last_switch_q;

		// rounded tempo * n / d as (2 * tempo * n + d) / (2 * d)
		n_a   = mult_num(code_a);
		d_a   = mult_den(code_a);
		tn_a  = (n_a == 2'd3) ? ({2'd0, tempo_a} + {1'b0, tempo_a, 1'b0}) : {2'd0, tempo_a};
		dvd_a = {1'b0, tn_a, 1'b0} + {17'd0, d_a};
		dvs_a = {d_a, 1'b0};
		div_a = sw_chg_a && tm_a;
	end

	// ---------------------------------------------------------------- phase b
	// pot, first tap, timeouts, release and later tap
	logic              pot_mv, ft, to1, to2, tmo, rel, lt;
	logic [DATA_W-1:0] pot_diff, drive_b, el_b1, el_b2, el2, tempo_b, lpot_b, lsw_b;
	logic [19:0]       pot_prod;
	logic [FCW-1:0]    fc_b1;
	logic [TCNT_W-1:0] tcnt_b1, tcnt_b2, tcnt_inc;
	logic              held_b1, held_b2, tapping_b1, tapping_b2, tm_b1;
	logic [17:0]       triple, el_n, rhs, el2n;
	logic [18:0]       div_d_prod;
	logic [DIVD_W-1:0] dvd_b;
	logic [DIVS_W-1:0] dvs_b;
	logic [DATA_W:0]   tempo_sum;
	logic [1:0]        n_b;
	logic [2:0]        d_b;

	always_comb begin
		n_b = mult_num(code_q);
		d_b = mult_den(code_q);

		pot_diff = abs_diff(last_pot_q, pot_ext);
		pot_mv   = !tapping_q && ((tap_mode_q && (pot_diff >= POT_JUMP_TAP)) ||
			(!tap_mode_q && (pot_diff != '0)));
		pot_prod = pot_q * pot_scale_q;
		drive_b  = pot_mv ? sat_from20(pot_prod) : drive_q;
		tm_b1    = pot_mv ? 1'b0 : tap_mode_q;

		ft         = btn_q && !held_q && (tap_count_q == '0);
		fc_b1      = ft ? '0 : fine_count_q;
		el_b1      = ft ? '0 : elapsed_q;
		tcnt_b1    = ft ? 8'd1 : tap_count_q;
		held_b1    = ft || held_q;
		tapping_b1 = ft || tapping_q;

		triple = {2'd0, tempo_q} + {1'b0, tempo_q, 1'b0};
		el_n   = (n_b == 2'd3) ? ({2'd0, el_b1} + {1'b0, el_b1, 1'b0}) : {2'd0, el_b1};
		rhs    = {8'd0, delay_max_q} * {15'd0, d_b} + {6'd0, SINGLE_SLACK} * {16'd0, n_b};
		to1    = (tcnt_b1 > 8'd1) && !btn_q && !held_b1 && ({2'd0, el_b1} > triple);
		to2    = !to1 && (tcnt_b1 == 8'd1) && !btn_q && !held_b1 && (el_n > rhs);
		tmo    = to1 || to2;

		el_b2      = tmo ? '0 : el_b1;
		tcnt_b2    = tmo ? '0 : tcnt_b1;
		tapping_b2 = tmo ? 1'b0 : tapping_b1;

		rel     = !btn_q && held_b1;
		held_b2 = rel ? 1'b0 : held_b1;
		lpot_b  = (pot_mv || rel) ? pot_ext : last_pot_q;
		lsw_b   = rel ? sw_ext : last_switch_q;

		lt       = btn_q && !held_b2 && (tcnt_b2 != '0) && (el_b2 >= MIN_TAP_MS);
		el2      = (fc_b1 >= FCW'(HALF)) ? sat_inc(el_b2) : el_b2;
		el2n     = (n_b == 2'd3) ? ({2'd0, el2} + {1'b0, el2, 1'b0}) : {2'd0, el2};
		tcnt_inc = (tcnt_b2 == TCNT_MAX) ? tcnt_b2 : tcnt_b2 + 1'b1;

		// first interval sets tempo, later ones average into it
		div_d_prod = {3'd0, divided_q} * {16'd0, d_b};
		tempo_sum  = {1'b0, tempo_q} + {1'b0, el2};
		if (tcnt_b2 == 8'd1) begin
			dvd_b   = {2'd0, el2n};
			dvs_b   = {1'b0, d_b};
			tempo_b = el2;
		end else begin
			dvd_b   = {1'b0, div_d_prod} + {2'd0, el2n};
			dvs_b   = {d_b, 1'b0};
			tempo_b = tempo_sum[DATA_W:1];
		end
	end

	// ---------------------------------------------------------------- phase c
	// beat led
	logic              blk, beat, led_c1, led_c2, led_c;
	logic [DATA_W-1:0] bl_c;

	always_comb begin
		led_c1 = (!tap_mode_q && !tapping_q) ? 1'b1 : led_q;
		led_c2 = (tapping_q && (tap_count_q == 8'd1) && held_q) ? 1'b0 : led_c1;
		blk    = tap_mode_q && !tapping_q && !btn_q;
		beat   = $signed({2'd0, blink_q}) >= ($signed({2'd0, tempo_q}) - $signed(BLINK_LEAD));
		bl_c   = (blk && beat) ? '0 : blink_q;
		if (blk)
			led_c = (bl_c >= BLINK_ON_MS) ? 1'b0 : (beat ? 1'b1 : led_c2);
		else
			led_c = led_c2;
	end

	// ---------------------------------------------------------------- divider step
	logic [REM_W:0] trial;
	logic           trial_ge;

	assign trial    = {rem_q, quo_q[DIVD_W-1]};
	assign trial_ge = trial >= {1'b0, divs_q};

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fine_count_q  <= '0;
			elapsed_q     <= '0;
			blink_q       <= '0;
			tap_count_q   <= '0;
			held_q        <= 1'b0;
			tapping_q     <= 1'b0;
			tap_mode_q    <= START_TAP_RST;
			tempo_q       <= START_TEMPO_RST;
			divided_q     <= DRIVE_INIT;
			code_q        <= '0;
			last_switch_q <= LAST_INIT;
			last_pot_q    <= LAST_INIT;
			drive_q       <= DRIVE_INIT;
			led_q         <= 1'b0;
			first_seen_q  <= 1'b0;
			quo_q         <= '0;
			rem_q         <= '0;
			divs_q        <= '0;
			div_cnt_q     <= '0;
			div_from_b_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			out_delay_q   <= '0;
			out_led_q     <= 1'b0;
			out_tap_q     <= 1'b0;
		end else begin
			if (out_take)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_take)
						state_q <= S_A;
				end
				S_A: begin
					first_seen_q  <= 1'b1;
					tap_mode_q    <= tm_a;
					tempo_q       <= tempo_a;
					last_pot_q    <= lpot_a;
					fine_count_q  <= fc_a;
					elapsed_q     <= el_a;
					blink_q       <= bl_a;
					code_q        <= code_a;
					tap_count_q   <= tcnt_a;
					tapping_q     <= tapping_a;
					held_q        <= held_a;
					last_switch_q <= lsw_a;
					if (div_a) begin
						quo_q        <= dvd_a;
						rem_q        <= '0;
						divs_q       <= dvs_a;
						div_cnt_q    <= '0;
						div_from_b_q <= 1'b0;
						state_q      <= S_DIV;
					end else begin
						state_q <= S_B;
					end
				end
				S_B: begin
					drive_q       <= drive_b;
					last_pot_q    <= lpot_b;
					last_switch_q <= lsw_b;
					tapping_q     <= tapping_b2;
					tap_mode_q    <= lt ? 1'b1 : tm_b1;
					fine_count_q  <= lt ? '0 : fc_b1;
					elapsed_q     <= lt ? '0 : el_b2;
					blink_q       <= lt ? '0 : blink_q;
					tap_count_q   <= lt ? tcnt_inc : tcnt_b2;
					held_q        <= lt ? 1'b1 : held_b2;
					tempo_q       <= lt ? tempo_b : tempo_q;
					led_q         <= lt ? 1'b1 : (rel ? 1'b0 : led_q);
					if (lt) begin
						quo_q        <= dvd_b;
						rem_q        <= '0;
						divs_q       <= dvs_b;
						div_cnt_q    <= '0;
						div_from_b_q <= 1'b1;
						state_q      <= S_DIV;
					end else begin
						state_q <= S_C;
					end
				end
				S_DIV: begin
					// one restoring step: quotient bit shifts in at the bottom
					quo_q <= {quo_q[DIVD_W-2:0], trial_ge};
					rem_q <= trial_ge ? REM_W'(trial - {1'b0, divs_q}) : trial[REM_W-1:0];
					if (div_cnt_q == CNT_W'(DIVD_W - 1))
						state_q <= S_WR;
					else
						div_cnt_q <= div_cnt_q + 1'b1;
				end
				S_WR: begin
					divided_q <= sat_from20(quo_q);
					drive_q   <= sat_from20(quo_q);
					state_q   <= div_from_b_q ? S_C : S_B;
				end
				S_C: begin
					blink_q     <= bl_c;
					led_q       <= led_c;
					out_valid_q <= 1'b1;
					out_delay_q <= drive_q;
					out_led_q   <= led_c;
					out_tap_q   <= tap_mode_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- checks
	`TT_ASSERT_NXT(a_take_starts, in_take, state_q == S_A)
	`TT_ASSERT_IMP(a_tap_count, tapping_q, tap_count_q != '0)
	`TT_ASSERT_IMP(a_div_bound, state_q == S_DIV, div_cnt_q <= CNT_W'(DIVD_W - 1))
	`TT_ASSERT_IMP(a_out_from_c, $rose(out_valid_q), $past(state_q) == S_C)
	`TT_ASSERT_IMP(a_hold_input, out_valid_q, in_stall)

endmodule

`default_nettype wire
